// ===== sv/sha_pkg.sv =====
// Package with SHA-256 constants, round functions and shared types.
`timescale 1ns / 1ps
package sha_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;

    // One queue entry passed from the front end to the core
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       is_last;
    } t_entry;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k [0:63];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[t];
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== sv/sha_queue.sv =====
// Short item queue between the input side and the hash core.
`timescale 1ns / 1ps
module sha_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sha_pkg::t_entry i_entry,
    output logic            o_valid,
    input  logic            i_ready,
    output sha_pkg::t_entry o_entry
);
    sha_pkg::t_entry                r_mem [0:sha_pkg::QUEUE_DEPTH-1];
    logic [sha_pkg::QPTR_W-1:0]     r_wr;
    logic [sha_pkg::QPTR_W-1:0]     r_rd;
    logic [sha_pkg::QPTR_W:0]       r_cnt;
    logic                           w_push;
    logic                           w_pop;

    assign o_ready = (r_cnt != 3'(sha_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Store the item at the write pointer
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + {2'b0, w_push} - {2'b0, w_pop};
        end
    end

    // Count never exceeds depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(sha_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");
    // A push with no pop grows the count by one
    a_cnt_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_cnt == $past(r_cnt) + 3'd1)
        else $error("queue count mismatch on push");
    // A pop with no push shrinks the count by one
    a_cnt_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> r_cnt == $past(r_cnt) - 3'd1)
        else $error("queue count mismatch on pop");
endmodule

// ===== sv/sha_core.sv =====
// Hash core: byte buffer, padding sequencer, 64-round compression, digest output.
`timescale 1ns / 1ps
module sha_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sha_pkg::t_entry i_entry,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [63:0]     o_digest_word,
    output logic [1:0]      o_word_index,
    output logic            o_last_word
);
    typedef enum logic [2:0] {
        ST_TAKE, ST_PAD, ST_LOAD, ST_ROUND, ST_ADD, ST_OUT
    } t_state;

    t_state         r_state;
    logic [31:0]    r_buf [0:15];
    logic [5:0]     r_fill;
    logic [63:0]    r_len;
    logic [255:0]   r_hash;
    logic [31:0]    r_w [0:15];
    logic [31:0]    r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [5:0]     r_rnd;
    logic           r_final;   // compression in flight belongs to the ending message
    logic           r_pad80;   // the 0x80 pad byte is still to be placed
    logic           r_nolen;   // this block is zero filled, the length goes in the next
    logic [1:0]     r_idx;
    logic           r_ovalid;

    logic [31:0]    w_wt;
    logic [31:0]    w_new;
    logic [31:0]    w_t1;
    logic [31:0]    w_t2;
    logic [7:0]     w_pbyte;
    logic [31:0]    w_merged;

    assign o_ready       = (r_state == ST_TAKE);
    assign o_valid       = r_ovalid;
    assign o_digest_word = r_hash[255 - 64*r_idx -: 64];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 2'd3);

    // Schedule word: shift register holds the last 16 words
    assign w_new = sha_pkg::small_s1(r_w[14]) + r_w[9] + sha_pkg::small_s0(r_w[1]) + r_w[0];
    assign w_wt  = (r_rnd < 6'd16) ? r_w[r_rnd[3:0]] : w_new;
    assign w_t1  = r_h + sha_pkg::big_s1(r_e) + ((r_e & r_f) ^ (~r_e & r_g)) +
                   sha_pkg::round_k(r_rnd) + w_wt;
    assign w_t2  = sha_pkg::big_s0(r_a) + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));

    // Byte written into the buffer word at the fill position
    always_comb begin
        w_pbyte = '0;
        if (r_state == ST_TAKE) begin
            w_pbyte = i_entry.data_byte;
        end else if (r_pad80) begin
            w_pbyte = sha_pkg::PAD_BYTE;
        end else if (r_fill >= sha_pkg::LEN_OFFSET && !r_nolen) begin
            w_pbyte = r_len[63 - 8*(r_fill - sha_pkg::LEN_OFFSET) -: 8];
        end
        w_merged = r_buf[r_fill[5:2]];
        w_merged[31 - 8*r_fill[1:0] -: 8] = w_pbyte;
    end

    // Sequence item intake, padding, compression and digest output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_TAKE;
            r_fill   <= '0;
            r_len    <= '0;
            r_hash   <= sha_pkg::INIT_HASH;
            r_final  <= 1'b0;
            r_pad80  <= 1'b0;
            r_nolen  <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                ST_TAKE: begin
                    if (i_valid) begin
                        if (i_entry.byte_present) begin
                            r_buf[r_fill[5:2]] <= w_merged;
                            r_fill <= r_fill + 6'd1;
                            r_len  <= r_len + 64'd1;
                        end
                        r_final <= i_entry.is_last;
                        r_pad80 <= i_entry.is_last;
                        r_nolen <= 1'b0;
                        if (i_entry.byte_present && r_fill == 6'd63) begin
                            r_state <= ST_LOAD;
                        end else if (i_entry.is_last) begin
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    // Place 0x80 if due, then zeros, then the bit length at the tail unless r_nolen is set
                    r_buf[r_fill[5:2]] <= w_merged;
                    r_fill <= r_fill + 6'd1;
                    if (r_pad80) begin
                        r_pad80 <= 1'b0;
                        r_len   <= {r_len[60:0], 3'b000};
                        r_nolen <= (r_fill >= sha_pkg::LEN_OFFSET);
                    end
                    if (r_fill == 6'd63) r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    for (int i = 0; i < 16; i++) r_w[i] <= r_buf[i];
                    {r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h} <= r_hash;
                    r_rnd   <= '0;
                    r_fill  <= '0;
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    r_h <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + w_t1;
                    r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= w_t1 + w_t2;
                    if (r_rnd >= 6'd16) begin
                        for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                        r_w[15] <= w_new;
                    end
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_hash <= {r_hash[255:224] + r_a, r_hash[223:192] + r_b,
                               r_hash[191:160] + r_c, r_hash[159:128] + r_d,
                               r_hash[127:96]  + r_e, r_hash[95:64]   + r_f,
                               r_hash[63:32]   + r_g, r_hash[31:0]    + r_h};
                    if (r_final && (r_pad80 || r_nolen)) begin
                        // full last block done, or 0x80 overflowed: pad a new block
                        r_state <= ST_PAD;
                        r_nolen <= 1'b0;
                    end else if (r_final) begin
                        r_state  <= ST_OUT;
                        r_idx    <= '0;
                        r_ovalid <= 1'b1;
                    end else begin
                        r_state <= ST_TAKE;
                    end
                end
                ST_OUT: begin
                    if (i_ready) begin
                        r_idx <= r_idx + 2'd1;
                        if (r_idx == 2'd3) begin
                            r_ovalid <= 1'b0;
                            r_hash   <= sha_pkg::INIT_HASH;
                            r_len    <= '0;
                            r_final  <= 1'b0;
                            r_state  <= ST_TAKE;
                        end
                    end
                end
                default: r_state <= ST_TAKE;
            endcase
        end
    end

    // Output valid only while presenting the digest
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_state == ST_OUT)
        else $error("digest valid outside output state");
    // Intake closed while compressing
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> !o_ready)
        else $error("ready during rounds");
    // Round counter wraps into the add step
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_rnd == 6'd63) |=> r_state == ST_ADD)
        else $error("round sequence broken");
endmodule

// ===== sv/sha256_stream_hash.sv =====
// Top level of the streaming SHA-256 hasher.
//
// Usage: present one item per handshake on the input channel (i_valid /
// o_ready) with i_data_byte, i_byte_present and i_is_last. Bytes are packed
// into 64-byte blocks; each full block runs 64 rounds, one round per cycle
// in a single shared round unit, plus a load step and an add step.
// The core accepts no bytes while it compresses a block, so sustained
// throughput is set by the round loop.
// A four-entry queue in front of the core lets the sender run ahead while
// the core compresses.
// On an item with i_is_last the core pads the message (up to 72 pad bytes
// over two blocks) and runs one or two compressions, then
// offers four 64-bit digest words on o_valid / i_ready, word 0 first,
// o_last_word on word 3.
// If the receiver stalls, the current digest word holds and intake waits.
// After the last word the chaining value returns to the initial value.
// Reset (i_rst_n low, synchronous) empties the queue and starts a new
// message.
`timescale 1ns / 1ps
module sha256_stream_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);
    sha_pkg::t_entry w_in;
    sha_pkg::t_entry w_q;
    logic            w_qvalid;
    logic            w_qready;

    assign w_in.data_byte    = i_data_byte;
    assign w_in.byte_present = i_byte_present;
    assign w_in.is_last      = i_is_last;

    // Buffer items ahead of the core
    sha_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_entry (w_in),
        .o_valid (w_qvalid),
        .i_ready (w_qready),
        .o_entry (w_q)
    );

    // Hash items and deliver the digest
    sha_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_qvalid),
        .o_ready       (w_qready),
        .i_entry       (w_q),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );
endmodule

// ===== sim/tb_sha256_stream_hash.sv =====
// Self-checking testbench for the streaming SHA-256 hasher.
`timescale 1ns / 1ps
module tb_sha256_stream_hash;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       is_last;
    } t_msg_item;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_digest_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_byte_present;
    logic        i_is_last;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_digest_word;
    logic [1:0]  o_word_index;
    logic        o_last_word;

    sha256_stream_hash u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_digest_word  (o_digest_word),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word)
    );

    t_msg_item   pending_items[$];
    t_digest_out expected_digests[$];

    // Predictor state
    logic [31:0] hash_state [0:7];
    logic [7:0]  blk_bytes [0:63];
    int unsigned blk_fill;
    logic [63:0] byte_total;

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  failed;
    int  msg_bytes_left;

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Compress the held block into the chaining value
    task automatic hash_block();
        logic [31:0] sched [0:63];
        logic [31:0] va, vb, vc, vd, ve, vf, vg, vh, t1, t2;
        for (int t = 0; t < 16; t++)
            sched[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2],
                        blk_bytes[4*t+3]};
        for (int t = 16; t < 64; t++)
            sched[t] = (rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10))
                     + sched[t-7]
                     + (rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3))
                     + sched[t-16];
        va = hash_state[0]; vb = hash_state[1]; vc = hash_state[2]; vd = hash_state[3];
        ve = hash_state[4]; vf = hash_state[5]; vg = hash_state[6]; vh = hash_state[7];
        for (int t = 0; t < 64; t++) begin
            t1 = vh + (rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25))
               + ((ve & vf) ^ (~ve & vg)) + sha_pkg::round_k(6'(t)) + sched[t];
            t2 = (rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22))
               + ((va & vb) ^ (va & vc) ^ (vb & vc));
            vh = vg; vg = vf; vf = ve; ve = vd + t1;
            vd = vc; vc = vb; vb = va; va = t1 + t2;
        end
        hash_state[0] += va; hash_state[1] += vb; hash_state[2] += vc;
        hash_state[3] += vd; hash_state[4] += ve; hash_state[5] += vf;
        hash_state[6] += vg; hash_state[7] += vh;
    endtask

    task automatic restart_message();
        for (int k = 0; k < 8; k++)
            hash_state[k] = sha_pkg::INIT_HASH[255 - 32*k -: 32];
        blk_fill   = 0;
        byte_total = '0;
    endtask

    // Advance the predictor by one accepted item
    task automatic predict_digest(input t_msg_item it);
        logic [63:0] bit_len;
        t_digest_out dw;
        if (it.byte_present) begin
            blk_bytes[blk_fill] = it.data_byte;
            blk_fill++;
            byte_total++;
            if (blk_fill == 64) begin
                hash_block();
                blk_fill = 0;
            end
        end
        if (!it.is_last)
            return;
        bit_len = byte_total << 3;
        blk_bytes[blk_fill] = sha_pkg::PAD_BYTE;
        blk_fill++;
        if (blk_fill > 56) begin
            while (blk_fill < 64) begin
                blk_bytes[blk_fill] = 8'h00;
                blk_fill++;
            end
            hash_block();
            blk_fill = 0;
        end
        while (blk_fill < 56) begin
            blk_bytes[blk_fill] = 8'h00;
            blk_fill++;
        end
        for (int k = 0; k < 8; k++)
            blk_bytes[56 + k] = bit_len[63 - 8*k -: 8];
        hash_block();
        for (int k = 0; k < 4; k++) begin
            dw.digest_word = {hash_state[2*k], hash_state[2*k+1]};
            dw.word_index  = k[1:0];
            dw.last_word   = (k == 3);
            expected_digests.push_back(dw);
        end
        restart_message();
    endtask

    function automatic t_msg_item make_item(input logic [7:0] b, input bit present,
                                            input bit last);
        t_msg_item it;
        it.data_byte    = b;
        it.byte_present = present;
        it.is_last      = last;
        return it;
    endfunction

    // Queue one message of n bytes, with optional empty items mixed in
    task automatic queue_message(input int n, input bit noisy, input bit byte_on_last);
        int body;
        body = (byte_on_last && n > 0) ? n - 1 : n;
        for (int k = 0; k < body; k++) begin
            if (noisy && $urandom_range(0, 9) == 0)
                pending_items.push_back(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            pending_items.push_back(make_item(8'($urandom_range(0, 255)), 1'b1, 1'b0));
        end
        pending_items.push_back(make_item(8'($urandom_range(0, 255)),
                                          byte_on_last && n > 0, 1'b1));
    endtask

    // Driver: present the next pending item, hold it until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_valid        <= 1'b1;
                i_data_byte    <= pending_items[0].data_byte;
                i_byte_present <= pending_items[0].byte_present;
                i_is_last      <= pending_items[0].is_last;
                void'(pending_items.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Predict on each accepted item
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            predict_digest(make_item(i_data_byte, i_byte_present, i_is_last));
    end

    // Monitor: check each accepted digest word, stall the receiver at random
    always @(posedge i_clk) begin
        t_digest_out exp_w;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_digests.size() == 0) begin
                $display("%0t: unexpected digest word %h idx %0d last %0b", $time,
                         o_digest_word, o_word_index, o_last_word);
                failed = 1'b1;
            end else begin
                exp_w = expected_digests.pop_front();
                if (o_digest_word !== exp_w.digest_word) begin
                    $display("%0t: digest_word expected %h actual %h", $time,
                             exp_w.digest_word, o_digest_word);
                    failed = 1'b1;
                end
                if (o_word_index !== exp_w.word_index) begin
                    $display("%0t: word_index expected %0d actual %0d", $time,
                             exp_w.word_index, o_word_index);
                    failed = 1'b1;
                end
                if (o_last_word !== exp_w.last_word) begin
                    $display("%0t: last_word expected %0b actual %0b", $time,
                             exp_w.last_word, o_last_word);
                    failed = 1'b1;
                end
            end
        end
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Stimulus
    initial begin
        failed         = 1'b0;
        send_idle_pct  = 12;
        recv_idle_pct  = 45;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_data_byte    = '0;
        i_byte_present = 1'b0;
        i_is_last      = 1'b0;
        restart_message();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty message, idle items, extreme bytes, padding boundaries
        pending_items.push_back(make_item(8'hff, 1'b0, 1'b0));
        pending_items.push_back(make_item(8'h00, 1'b0, 1'b1));
        pending_items.push_back(make_item(8'h00, 1'b1, 1'b0));
        pending_items.push_back(make_item(8'hff, 1'b1, 1'b1));
        pending_items.push_back(make_item(8'haa, 1'b0, 1'b0));
        pending_items.push_back(make_item(8'h55, 1'b1, 1'b0));
        pending_items.push_back(make_item(8'h5a, 1'b0, 1'b1));
        pending_items.push_back(make_item(8'h00, 1'b0, 1'b1));
        queue_message(55, 1'b0, 1'b1);
        queue_message(56, 1'b0, 1'b0);

        // Random messages, three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            msg_bytes_left = 35;
            while (msg_bytes_left > 0) begin
                int n;
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 70)
                                                : $urandom_range(0, 12);
                queue_message(n, 1'b1, 1'($urandom_range(0, 1)));
                msg_bytes_left -= n + 1;
            end
            wait (pending_items.size() == 0);
            @(posedge i_clk);
            while (i_valid || expected_digests.size() > 0)
                @(posedge i_clk);
            if (phase == 0) begin
                send_idle_pct = 45;
                recv_idle_pct = 12;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end
        repeat (200) @(posedge i_clk);
        if (!failed && expected_digests.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Timeout
    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== sha256_stream_hash.f =====
sv/sha_pkg.sv
sv/sha_queue.sv
sv/sha_core.sv
sv/sha256_stream_hash.sv
sim/tb_sha256_stream_hash.sv
